/* rtl/bdq_pkg.sv */
// bounded deque package: command and status codes, cell control word
// used by bdq_if.sv, bdq_cell.sv and bounded_deque_with_value_removal_top.sv
package bdq_pkg;

  // default geometry
  localparam int DepthDefault     = 64;
  localparam int DataWidthDefault = 32;

  // fixed payload widths of the channels
  localparam int CmdW    = 3;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // what every cell does in the execute cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;    // data update in the execute cycle
    logic     load;  // capture the match flag for a new word
  } cell_ctl_t;

endpackage

/* rtl/bdq_if.sv */
// valid/ready channel interfaces for the command and result words
// depends on bdq_pkg
interface bdq_req_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::CmdW-1:0]   cmd;
  logic [bdq_pkg::ValueW-1:0] value_in;

  modport source (output valid, cmd, value_in, input ready);
  modport sink   (input valid, cmd, value_in, output ready);
endinterface

interface bdq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bdq_pkg::ValueW-1:0]  value_out;
  logic [bdq_pkg::StatusW-1:0] status;
  logic [bdq_pkg::CountW-1:0]  count;

  modport source (output valid, value_out, status, count, input ready);
  modport sink   (input valid, value_out, status, count, output ready);
endinterface

/* rtl/bounded_deque_with_value_removal_top.sv */
// bounded deque top: command staging, cell chain, result register
// depends on bdq_pkg, bdq_if.sv, bdq_cell.sv
//
// Usage:
//   req carries one command word (cmd, value_in); rsp returns one result
//   word (value_out, status, count) for every command, in order.
//   Elements sit packed in a chain of cells, front in cell 0. Every cell
//   compares its element with the key at once, so remove needs no search loop.
//   A word accepted on req passes through the stage register, then the
//   result register when rsp is not stalled.
//   A new command is accepted only once the staged one has executed;
//   accepting a word registers the per-cell match flags, and executing it
//   shifts the chain and loads the result register.
//   When the receiver stalls, the result register holds its word and one
//   further command may be accepted; req.ready stays low while it waits in
//   the stage register, and it executes at the edge the result is taken.
//   Reset (rst, synchronous) empties the queue and both registers; the
//   cell contents are left as they are and are never read unoccupied.
module bounded_deque_with_value_removal_top #(
  parameter int DEPTH      = bdq_pkg::DepthDefault,
  parameter int DATA_WIDTH = bdq_pkg::DataWidthDefault
) (
  input  logic       clk,
  input  logic       rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // stage register
  logic                   s1_valid;
  bdq_pkg::cmd_t          s1_cmd;
  logic [DATA_WIDTH-1:0]  s1_val;

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;

  logic                   load;
  logic                   exec;
  logic                   full;
  logic                   empty;
  logic                   found;
  logic [DATA_WIDTH-1:0]  req_val;
  logic [DATA_WIDTH-1:0]  bus_val;
  logic [DATA_WIDTH-1:0]  back_val;
  logic [DATA_WIDTH-1:0]  pop_val;
  bdq_pkg::status_t       status_next;
  bdq_pkg::cell_ctl_t     ctl;

  logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]  cell_pick [DEPTH];
  logic                   cell_hit  [DEPTH+1];

  // handshake
  assign req.ready = !s1_valid;
  assign load      = req.valid && !s1_valid;
  assign exec      = s1_valid && (!rsp.valid || rsp.ready);

  // key bus: new word at load, staged word at execute (never both)
  assign req_val = DATA_WIDTH'(64'(req.value_in));
  assign bus_val = s1_valid ? s1_val : req_val;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign found = cell_hit[DEPTH];

  // per-cell command decode with full/empty gating
  always_comb begin
    ctl.load    = load;
    ctl.op      = bdq_pkg::CELL_HOLD;
    count_next  = count;
    status_next = bdq_pkg::ST_OK;
    pop_val     = '0;
    if (exec) begin
      unique case (s1_cmd)
        bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_next = bdq_pkg::ST_FULL;
          end else begin
            ctl.op     = (s1_cmd == bdq_pkg::CMD_PUSH_FRONT) ?
                         bdq_pkg::CELL_PUSH_FRONT : bdq_pkg::CELL_PUSH_BACK;
            count_next = count + CNT_W'(1);
          end
        end
        bdq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else begin
            ctl.op     = bdq_pkg::CELL_POP_FRONT;
            pop_val    = cell_data[0];
            count_next = count - CNT_W'(1);
          end
        end
        bdq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else begin
            pop_val    = back_val;
            count_next = count - CNT_W'(1);
          end
        end
        bdq_pkg::CMD_REMOVE: begin
          ctl.op = bdq_pkg::CELL_REMOVE;
          if (found) begin
            count_next = count - CNT_W'(1);
          end else begin
            status_next = bdq_pkg::ST_NOT_FOUND;
          end
        end
        bdq_pkg::CMD_CLEAR: count_next = '0;
        default: count_next = count;
      endcase
    end
  end

  // back element: only the tail cell drives its pick
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | cell_pick[i];
    end
  end

  // cell chain
  assign cell_hit[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (g == 0) begin : g_head
      assign left = bus_val;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_data[g+1];
    end
    bdq_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .val       (bus_val),
      .count     (count),
      .left      (left),
      .right     (right),
      .hit_in    (cell_hit[g]),
      .data      (cell_data[g]),
      .hit_out   (cell_hit[g+1]),
      .back_pick (cell_pick[g])
    );
  end

  // stage register and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count    <= '0;
    end else begin
      count <= count_next;
      if (load) begin
        s1_valid <= 1'b1;
      end else if (exec) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_cmd <= bdq_pkg::cmd_t'(req.cmd);
      s1_val <= req_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp.value_out <= bdq_pkg::ValueW'(64'(pop_val));
      rsp.status    <= status_next;
      rsp.count     <= bdq_pkg::CountW'(64'(count_next));
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill level beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    exec && !full &&
    (s1_cmd == bdq_pkg::CMD_PUSH_FRONT || s1_cmd == bdq_pkg::CMD_PUSH_BACK)
    |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow the queue");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    exec && empty &&
    (s1_cmd == bdq_pkg::CMD_POP_FRONT || s1_cmd == bdq_pkg::CMD_POP_BACK)
    |=> rsp.valid && rsp.status == bdq_pkg::ST_EMPTY && rsp.value_out == '0)
    else $error("pop on empty queue misreported");

  a_remove_miss: assert property (@(posedge clk) disable iff (rst)
    exec && s1_cmd == bdq_pkg::CMD_REMOVE && !found
    |=> count == $past(count) && rsp.status == bdq_pkg::ST_NOT_FOUND)
    else $error("failed remove changed the queue");

  a_stall_no_exec: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp.valid && !rsp.ready |=> s1_valid)
    else $error("staged word lost while result stalled");
`endif

endmodule

/* rtl/bdq_cell.sv */
// one storage cell of the deque chain: element, match flag, neighbor shifts
// depends on bdq_pkg
module bdq_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = bdq_pkg::DataWidthDefault,
  parameter int CNT_W      = 7
) (
  input  logic                   clk,
  input  bdq_pkg::cell_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0]  val,
  input  logic [CNT_W-1:0]       count,
  input  logic [DATA_WIDTH-1:0]  left,
  input  logic [DATA_WIDTH-1:0]  right,
  input  logic                   hit_in,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   hit_out,
  output logic [DATA_WIDTH-1:0]  back_pick
);

  logic match;
  logic occupied;
  logic is_tail;
  logic is_free_slot;

  // position of this cell against the current fill level
  assign occupied     = CNT_W'(IDX) < count;
  assign is_tail      = count == CNT_W'(IDX + 1);
  assign is_free_slot = count == CNT_W'(IDX);

  // first-match chain: set from the first matching cell onward
  assign hit_out   = hit_in | match;
  assign back_pick = is_tail ? data : '0;

  // match flag taken when a word is accepted
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      match <= occupied && (data == val);
    end
  end

  // element update
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bdq_pkg::CELL_PUSH_FRONT: data <= left;
      bdq_pkg::CELL_PUSH_BACK: begin
        if (is_free_slot) data <= val;
      end
      bdq_pkg::CELL_POP_FRONT: data <= right;
      bdq_pkg::CELL_REMOVE: begin
        if (hit_out) data <= right;
      end
      default: data <= data;
    endcase
  end

endmodule
